// ===== rtl/core/ghl_pkg.sv =====
// ----------------------------------------------------------------------------
// ghl_pkg
// shared constants for the grid histogram localisation block
// ----------------------------------------------------------------------------
package ghl_pkg;

  localparam int GRID_SIZE_DEF = 8;
  localparam int Q_W           = 17;
  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  // action codes
  localparam logic [2:0] ACT_STAY    = 3'd0;
  localparam logic [2:0] ACT_RIGHT   = 3'd1;
  localparam logic [2:0] ACT_LEFT    = 3'd2;
  localparam logic [2:0] ACT_DOWN    = 3'd3;
  localparam logic [2:0] ACT_UP      = 3'd4;
  localparam logic [2:0] ACT_MEASURE = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MOVE_PROB   = 2'd0;
  localparam logic [1:0] CFG_SENSOR_PROB = 2'd1;
  localparam logic [1:0] CFG_CELL_COLORS = 2'd2;

endpackage

// ===== rtl/core/grid_histogram_localization_top.sv =====
// ----------------------------------------------------------------------------
// grid_histogram_localization_top
// bayes histogram filter over a toroidal grid of red and green cells
// ----------------------------------------------------------------------------
// a command beat is taken when start is high and busy is low; the block then
// updates its belief grid and dumps every cell in row-major order, one result
// at a time marked by out_valid, with last on the final cell. the receiver
// cannot stall the dump. a stay only dumps the grid; a move blends each cell
// with its neighbour through the shared 17x17 multiplier; a measure forms
// the products with the same multiplier, then normalises each cell in a
// bit-serial divider, one quotient bit a cycle over 50 bits.
// configuration is taken at any time but must only be written while idle.
// ----------------------------------------------------------------------------
module grid_histogram_localization_top #(
  parameter int GRID_SIZE = ghl_pkg::GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            action,
  input  logic                  measured_red,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  output logic                  out_valid,
  output logic [2:0]            row,
  output logic [2:0]            column,
  output logic [ghl_pkg::Q_W-1:0] cell_probability,
  output logic                  degenerate,
  output logic                  last
);
  import ghl_pkg::*;

  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int CW        = (CELLS > 2) ? $clog2(CELLS) : 1;
  localparam int RW        = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int P_W       = 2 * Q_W;          // one product
  localparam int TOT_W     = P_W + CW;         // sum of all products
  localparam int DVD_W     = P_W + 16;         // product scaled by one
  localparam int DIV_STEPS = DVD_W;
  localparam int DC_W      = $clog2(DIV_STEPS + 1);
  localparam logic [Q_W-1:0] UNIFORM = Q_W'(65536 / CELLS);

  typedef enum logic [3:0] {
    S_IDLE, S_MV_RD, S_MV_M1, S_MV_M2, S_MV_WR,
    S_ME_RD, S_ME_MUL, S_ME_WR,
    S_DV_RD, S_DV_LD, S_DV_IT, S_DV_OUT,
    S_EM_RD, S_EM_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [Q_W-1:0] move_probability;
  logic [Q_W-1:0] sensor_probability;
  logic [63:0]    cell_colors;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_probability   <= Q_W'(52429);
      sensor_probability <= Q_W'(45875);
      cell_colors        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MOVE_PROB:   move_probability   <= cfg_data[Q_W-1:0];
        CFG_SENSOR_PROB: sensor_probability <= cfg_data[Q_W-1:0];
        CFG_CELL_COLORS: cell_colors        <= cfg_data;
        default: ;
      endcase
    end
  end

  // probabilities above one saturate
  logic [Q_W-1:0] pm, ps;
  assign pm = (move_probability > Q_ONE) ? Q_ONE : move_probability;
  assign ps = (sensor_probability > Q_ONE) ? Q_ONE : sensor_probability;

  // cell walk counters
  logic [CW-1:0] k;
  logic [RW-1:0] r, c;
  logic [2:0]    dir;
  logic          red;
  logic          copy;        // emit pass writes scratch back to belief
  logic          cell_last;
  assign cell_last = (k == CW'(CELLS - 1));

  // wrapped neighbour for a move
  logic [RW-1:0] sr, sc;
  logic [CW-1:0] nb;
  always_comb begin
    sr = r;
    sc = c;
    case (dir)
      ACT_RIGHT: sc = (c == '0) ? RW'(GRID_SIZE - 1) : c - 1'b1;
      ACT_LEFT:  sc = (c == RW'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
      ACT_DOWN:  sr = (r == '0) ? RW'(GRID_SIZE - 1) : r - 1'b1;
      default:   sr = (r == RW'(GRID_SIZE - 1)) ? '0 : r + 1'b1;
    endcase
    nb = CW'(sr * GRID_SIZE + sc);
  end

  // belief memory with per-entry valid bits; an unwritten entry is uniform
  logic [Q_W-1:0] bel_mem [CELLS];
  logic [CELLS-1:0] bel_vld;
  logic [Q_W-1:0] a_q, b_q;
  logic           a_v, b_v;
  logic           bel_we, bel_clr;
  logic [Q_W-1:0] bel_wdata;

  always_ff @(posedge clk) begin
    if (bel_we) bel_mem[k] <= bel_wdata;
    a_q <= bel_mem[k];
    b_q <= bel_mem[nb];
  end

  always_ff @(posedge clk) begin
    if (rst || bel_clr) begin
      bel_vld <= '0;
      a_v     <= 1'b0;
      b_v     <= 1'b0;
    end else begin
      if (bel_we) bel_vld[k] <= 1'b1;
      a_v <= bel_vld[k];
      b_v <= bel_vld[nb];
    end
  end

  logic [Q_W-1:0] a_eff, b_eff;
  assign a_eff = a_v ? a_q : UNIFORM;
  assign b_eff = b_v ? b_q : UNIFORM;

  // scratch memory: blended values of a move or products of a measure
  logic [P_W-1:0] scr_mem [CELLS];
  logic [P_W-1:0] s_q;
  logic           scr_we;
  logic [P_W-1:0] scr_wdata;

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[k] <= scr_wdata;
    s_q <= scr_mem[k];
  end

  // shared multiplier
  logic [Q_W-1:0] mul_a, mul_b;
  logic [P_W-1:0] prod, acc, mul_p;
  logic [Q_W-1:0] lik;
  assign lik = (cell_colors[6'(k)] == red) ? ps : Q_ONE - ps;

  always_comb begin
    mul_a = a_eff;
    mul_b = Q_ONE - pm;
    case (state)
      S_MV_M2:  begin mul_a = b_eff; mul_b = pm;  end
      S_ME_MUL: begin mul_a = a_eff; mul_b = lik; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic [P_W:0] blend;
  assign blend = {1'b0, acc} + {1'b0, prod};

  // serial divider state
  logic [TOT_W-1:0] total;
  logic [TOT_W:0]   rem;
  logic [DVD_W-1:0] dvd;
  logic [Q_W-1:0]   quo;
  logic [DC_W-1:0]  dcnt;
  logic [TOT_W:0]   rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem[TOT_W-1:0], dvd[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, total});

  // memory write control
  always_comb begin
    bel_we    = 1'b0;
    bel_wdata = s_q[Q_W-1:0];
    scr_we    = 1'b0;
    scr_wdata = prod;
    case (state)
      S_MV_WR: begin
        scr_we    = 1'b1;
        scr_wdata = P_W'(blend[P_W-2:16]);
      end
      S_ME_WR:  scr_we = 1'b1;
      S_EM_OUT: bel_we = copy;
      S_DV_OUT: begin
        bel_we    = 1'b1;
        bel_wdata = quo;
      end
      default: ;
    endcase
  end

  logic degen;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bel_clr   <= 1'b0;
      k         <= '0;
      r         <= '0;
      c         <= '0;
      degen     <= 1'b0;
      copy      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      bel_clr   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            k     <= '0;
            r     <= '0;
            c     <= '0;
            dir   <= action;
            red   <= measured_red;
            degen <= 1'b0;
            total <= '0;
            if (action == ACT_RIGHT || action == ACT_LEFT ||
                action == ACT_DOWN || action == ACT_UP) begin
              state <= S_MV_RD;
            end else if (action == ACT_MEASURE) begin
              state <= S_ME_RD;
            end else begin
              copy  <= 1'b0;
              state <= S_EM_RD;
            end
          end
        end
        // move: blend each cell with its neighbour into scratch
        S_MV_RD: state <= S_MV_M1;
        S_MV_M1: begin
          prod  <= mul_p;
          state <= S_MV_M2;
        end
        S_MV_M2: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (cell_last) begin
            copy  <= 1'b1;
            state <= S_EM_RD;
          end else begin
            state <= S_MV_RD;
          end
          k <= cell_last ? '0 : k + 1'b1;
          c <= (c == RW'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
          if (c == RW'(GRID_SIZE - 1)) r <= cell_last ? '0 : r + 1'b1;
        end
        // measure: products and their total
        S_ME_RD: state <= S_ME_RD == state ? S_ME_MUL : S_ME_RD;
        S_ME_MUL: begin
          prod  <= mul_p;
          state <= S_ME_WR;
        end
        S_ME_WR: begin
          total <= total + TOT_W'(prod);
          if (cell_last) begin
            if (total + TOT_W'(prod) == '0) begin
              degen   <= 1'b1;
              copy    <= 1'b0;
              bel_clr <= 1'b1;
              state   <= S_EM_RD;
            end else begin
              state <= S_DV_RD;
            end
          end else begin
            state <= S_ME_RD;
          end
          k <= cell_last ? '0 : k + 1'b1;
          c <= (c == RW'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
          if (c == RW'(GRID_SIZE - 1)) r <= cell_last ? '0 : r + 1'b1;
        end
        // normalise: one quotient bit a cycle
        S_DV_RD: state <= S_DV_LD;
        S_DV_LD: begin
          rem   <= '0;
          dvd   <= {s_q, 16'b0};
          quo   <= '0;
          dcnt  <= DC_W'(DIV_STEPS);
          state <= S_DV_IT;
        end
        S_DV_IT: begin
          rem  <= rem_ge ? rem_sh - {1'b0, total} : rem_sh;
          dvd  <= {dvd[DVD_W-2:0], 1'b0};
          quo  <= {quo[Q_W-2:0], rem_ge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == DC_W'(1)) state <= S_DV_OUT;
        end
        S_DV_OUT: begin
          out_valid        <= 1'b1;
          row              <= 3'(r);
          column           <= 3'(c);
          cell_probability <= quo;
          degenerate       <= degen;
          last             <= cell_last;
          state <= cell_last ? S_IDLE : S_DV_RD;
          k <= cell_last ? '0 : k + 1'b1;
          c <= (c == RW'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
          if (c == RW'(GRID_SIZE - 1)) r <= cell_last ? '0 : r + 1'b1;
        end
        // dump pass, writing back the move scratch where needed
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          out_valid        <= 1'b1;
          row              <= 3'(r);
          column           <= 3'(c);
          cell_probability <= copy ? s_q[Q_W-1:0] : a_eff;
          degenerate       <= degen;
          last             <= cell_last;
          state <= cell_last ? S_IDLE : S_EM_RD;
          k <= cell_last ? '0 : k + 1'b1;
          c <= (c == RW'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
          if (c == RW'(GRID_SIZE - 1)) r <= cell_last ? '0 : r + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the grid histogram localisation block: a local
// belief-grid predictor computes every cell dump, and each out_valid beat is
// compared field by field with the oldest predicted cell
// ----------------------------------------------------------------------------
module tb_top;

  import ghl_pkg::*;

  localparam int N     = GRID_SIZE_DEF;
  localparam int CELLS = N * N;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]     row;
    logic [2:0]     column;
    logic [Q_W-1:0] prob;
    logic           degenerate;
    logic           last;
  } cell_beat_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [2:0]      action;
  logic            measured_red;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [63:0]     cfg_data;
  logic            out_valid;
  logic [2:0]      row;
  logic [2:0]      column;
  logic [Q_W-1:0]  cell_probability;
  logic            degenerate;
  logic            last;

  // predictor state
  logic [16:0]     move_prob_q;
  logic [16:0]     sensor_prob_q;
  logic [63:0]     colour_map;
  logic [16:0]     belief [CELLS];

  cell_beat_t      expected_cells[$];
  int              error_count;
  int              idle_cycles;

  grid_histogram_localization_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .measured_red     (measured_red),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .row              (row),
    .column           (column),
    .cell_probability (cell_probability),
    .degenerate       (degenerate),
    .last             (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [16:0] sat_q(input logic [16:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  function automatic void set_uniform_belief();
    for (int k = 0; k < CELLS; k++) belief[k] = 17'(65536 / CELLS);
  endfunction

  // shift belief towards the commanded direction, wrapping at the edges
  function automatic void blend_move(input logic [2:0] dir);
    logic [16:0] prev [CELLS];
    logic [63:0] pm;
    logic [63:0] mix;
    int sr;
    int sc;
    pm = 64'(sat_q(move_prob_q));
    for (int k = 0; k < CELLS; k++) prev[k] = belief[k];
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        sr = r;
        sc = c;
        case (dir)
          ACT_RIGHT: sc = (c + N - 1) % N;
          ACT_LEFT:  sc = (c + 1) % N;
          ACT_DOWN:  sr = (r + N - 1) % N;
          default:   sr = (r + 1) % N;
        endcase
        mix = 64'(prev[r*N+c]) * (64'(Q_ONE) - pm) + 64'(prev[sr*N+sc]) * pm;
        belief[r*N+c] = 17'(mix >> 16);
      end
    end
  endfunction

  // bayes update by sensor likelihood, returns 1 when the total collapses
  function automatic bit weigh_by_sensor(input logic red);
    logic [63:0] products [CELLS];
    logic [63:0] ps;
    logic [63:0] total;
    ps = 64'(sat_q(sensor_prob_q));
    total = '0;
    for (int k = 0; k < CELLS; k++) begin
      products[k] = 64'(belief[k]) * ((colour_map[k] == red) ? ps : 64'(Q_ONE) - ps);
      total += products[k];
    end
    if (total == 0) begin
      set_uniform_belief();
      return 1'b1;
    end
    for (int k = 0; k < CELLS; k++) belief[k] = 17'((products[k] << 16) / total);
    return 1'b0;
  endfunction

  function automatic void predict_dump(input logic [2:0] act, input logic red);
    bit degen;
    cell_beat_t b;
    degen = 1'b0;
    if (act >= ACT_RIGHT && act <= ACT_UP) blend_move(act);
    else if (act == ACT_MEASURE) degen = weigh_by_sensor(red);
    for (int k = 0; k < CELLS; k++) begin
      b.row        = 3'(k / N);
      b.column     = 3'(k % N);
      b.prob       = belief[k];
      b.degenerate = degen;
      b.last       = (k == CELLS - 1);
      expected_cells.push_back(b);
    end
  endfunction

  // mostly short gaps, now and then a long one, often none
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) < 4) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_command(input logic [2:0] act, input logic red);
    // the previous beat's release settles before start rises again
    @(posedge clk);
    random_gap();
    start        <= 1'b1;
    action       <= act;
    measured_red <= red;
    do @(posedge clk); while (busy);
    predict_dump(act, red);
    start        <= 1'b0;
    action       <= 3'($urandom);
    measured_red <= 1'($urandom);
  endtask

  task automatic wait_idle();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MOVE_PROB:   move_prob_q   = value[16:0];
      CFG_SENSOR_PROB: sensor_prob_q = value[16:0];
      default:         colour_map    = value;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_command(ACT_STAY, 1'b0);
    send_command(ACT_MEASURE, 1'b1);
  endtask

  task automatic test_every_action();
    write_register(CFG_CELL_COLORS, 64'hF0F0_0F0F_AA55_1234);
    for (int a = 0; a < 8; a++) send_command(3'(a), 1'($urandom));
    send_command(ACT_MEASURE, 1'b0);
  endtask

  task automatic test_extremes();
    // certain move, then no move at all
    write_register(CFG_MOVE_PROB, 64'(Q_ONE));
    send_command(ACT_RIGHT, 1'b0);
    send_command(ACT_UP, 1'b0);
    write_register(CFG_MOVE_PROB, 64'd0);
    send_command(ACT_LEFT, 1'b0);
    // out-of-range register values saturate to one
    write_register(CFG_MOVE_PROB, 64'h1FFFF);
    send_command(ACT_DOWN, 1'b0);
    write_register(CFG_SENSOR_PROB, 64'h1FFFF);
    send_command(ACT_MEASURE, 1'b1);
    // all-red map with a perfect sensor that sees green: zero total
    write_register(CFG_CELL_COLORS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_SENSOR_PROB, 64'(Q_ONE));
    send_command(ACT_MEASURE, 1'b0);
    write_register(CFG_SENSOR_PROB, 64'd0);
    send_command(ACT_MEASURE, 1'b1);
    send_command(ACT_MEASURE, 1'b0);
  endtask

  task automatic test_random_sequences();
    logic [2:0] act;
    for (int phase = 0; phase < 6; phase++) begin
      write_register(CFG_MOVE_PROB, (phase % 3 == 0) ? 64'($urandom_range(0, 65536)) :
                     64'($urandom_range(0, 131071)));
      write_register(CFG_SENSOR_PROB, (phase == 2) ? 64'(Q_ONE) :
                     64'($urandom_range(0, 65536)));
      write_register(CFG_CELL_COLORS, {$urandom, $urandom});
      for (int i = 0; i < 45; i++) begin
        // measures and moves dominate, stay and undefined codes now and then
        act = ($urandom_range(0, 9) < 4) ? ACT_MEASURE :
              ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
        send_command(act, 1'($urandom));
      end
    end
  endtask

  // checker: one predicted cell per out_valid beat
  always @(posedge clk) begin
    cell_beat_t exp_b;
    if (!rst && out_valid) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("cell beat with nothing expected");
      end else begin
        exp_b = expected_cells.pop_front();
        if (row !== exp_b.row)
          report_mismatch($sformatf("row %0d, expected %0d", row, exp_b.row));
        if (column !== exp_b.column)
          report_mismatch($sformatf("column %0d, expected %0d", column, exp_b.column));
        if (cell_probability !== exp_b.prob)
          report_mismatch($sformatf("cell %0d,%0d probability %0d, expected %0d",
                                    exp_b.row, exp_b.column, cell_probability, exp_b.prob));
        if (degenerate !== exp_b.degenerate)
          report_mismatch($sformatf("degenerate %b, expected %b", degenerate,
                                    exp_b.degenerate));
        if (last !== exp_b.last)
          report_mismatch($sformatf("last %b, expected %b", last, exp_b.last));
      end
    end
  end

  // watchdog: cycles with no command, config or cell beat accepted
  always @(posedge clk) begin
    if (rst || out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    error_count   = 0;
    idle_cycles   = 0;
    rst           = 1'b1;
    start         = 1'b0;
    action        = ACT_STAY;
    measured_red  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_MOVE_PROB;
    cfg_data      = '0;
    move_prob_q   = 17'd52429;
    sensor_prob_q = 17'd45875;
    colour_map    = '0;
    set_uniform_belief();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_every_action();
    test_extremes();
    test_random_sequences();

    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
